// ----- rtl/sbct_pkg.sv -----
// shared constants for the segment versus box clip test
`timescale 1ns / 1ps

package sbct_pkg;

	// number of clip edges, visited in this order
	localparam int NUM_EDGES = 4;
	localparam int EDGE_X_LO = 0;
	localparam int EDGE_X_HI = 1;
	localparam int EDGE_Z_LO = 2;
	localparam int EDGE_Z_HI = 3;

	// stream word layout
	localparam int NUM_IN_FIELDS = 8;
	localparam int OUT_DATA_W    = 8;

endpackage

// ----- rtl/sbct_prep.sv -----
// input stage: edge distances p and q for all four clip edges
`timescale 1ns / 1ps

module sbct_prep import sbct_pkg::*; #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [COORD_WIDTH-1:0]          start_x,
	input  logic signed [COORD_WIDTH-1:0]          start_z,
	input  logic signed [COORD_WIDTH-1:0]          end_x,
	input  logic signed [COORD_WIDTH-1:0]          end_z,
	input  logic signed [COORD_WIDTH-1:0]          box_min_x,
	input  logic signed [COORD_WIDTH-1:0]          box_min_z,
	input  logic signed [COORD_WIDTH-1:0]          box_max_x,
	input  logic signed [COORD_WIDTH-1:0]          box_max_z,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [NUM_EDGES-1:0][COORD_WIDTH:0]    out_p,
	output logic [NUM_EDGES-1:0][COORD_WIDTH:0]    out_q
);

	localparam int V_W = COORD_WIDTH + 1;

	logic                          en_s1;
	logic                          valid_s1;
	logic signed [V_W-1:0]         ax, az, bx, bz, x0, z0, x1, z1;
	logic signed [V_W-1:0]         dx, dz;
	logic [NUM_EDGES-1:0][V_W-1:0] p_nx, q_nx;
	logic [NUM_EDGES-1:0][V_W-1:0] p_s1, q_s1;

	assign en_s1    = !valid_s1 || out_ready;
	assign in_ready = en_s1;

	// widen by one bit so every difference is exact
	always_comb begin
		ax = V_W'(start_x);
		az = V_W'(start_z);
		bx = V_W'(end_x);
		bz = V_W'(end_z);
		x0 = V_W'(box_min_x);
		z0 = V_W'(box_min_z);
		x1 = V_W'(box_max_x);
		z1 = V_W'(box_max_z);
		dx = bx - ax;
		dz = bz - az;
		p_nx[EDGE_X_LO] = -dx;
		q_nx[EDGE_X_LO] = ax - x0;
		p_nx[EDGE_X_HI] = dx;
		q_nx[EDGE_X_HI] = x1 - ax;
		p_nx[EDGE_Z_LO] = -dz;
		q_nx[EDGE_Z_LO] = az - z0;
		p_nx[EDGE_Z_HI] = dz;
		q_nx[EDGE_Z_HI] = z1 - az;
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			p_s1 <= p_nx;
			q_s1 <= q_nx;
		end
	end

	assign out_valid = valid_s1;
	assign out_p     = p_s1;
	assign out_q     = q_s1;

endmodule

// ----- rtl/sbct_edge.sv -----
// one clip edge: cross products, then bound compare and interval update
`timescale 1ns / 1ps

module sbct_edge import sbct_pkg::*; #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                in_fail,
	input  logic signed [COORD_WIDTH:0]         in_n0,
	input  logic signed [COORD_WIDTH:0]         in_d0,
	input  logic signed [COORD_WIDTH:0]         in_n1,
	input  logic signed [COORD_WIDTH:0]         in_d1,
	input  logic [NUM_EDGES-1:0][COORD_WIDTH:0] in_p,
	input  logic [NUM_EDGES-1:0][COORD_WIDTH:0] in_q,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                out_fail,
	output logic signed [COORD_WIDTH:0]         out_n0,
	output logic signed [COORD_WIDTH:0]         out_d0,
	output logic signed [COORD_WIDTH:0]         out_n1,
	output logic signed [COORD_WIDTH:0]         out_d1,
	output logic [NUM_EDGES-1:0][COORD_WIDTH:0] out_p,
	output logic [NUM_EDGES-1:0][COORD_WIDTH:0] out_q
);

	localparam int V_W = COORD_WIDTH + 1;
	localparam int P_W = 2 * V_W;

	logic                          en_s1, en_s2;
	logic                          valid_s1, valid_s2;
	logic signed [V_W-1:0]         p_cur, q_cur, num, den;
	logic                          p_neg, p_zero;
	logic [NUM_EDGES-1:0][V_W-1:0] p_rot, q_rot;

	// stage 1 registers
	logic signed [P_W-1:0]         prod_a_s1, prod_b_s1, prod_c_s1, prod_d_s1;
	logic signed [V_W-1:0]         num_s1, den_s1;
	logic signed [V_W-1:0]         n0_s1, d0_s1, n1_s1, d1_s1;
	logic                          neg_s1, zero_s1, qneg_s1, fail_s1;
	logic [NUM_EDGES-1:0][V_W-1:0] p_s1, q_s1;

	// stage 2 registers
	logic signed [V_W-1:0]         n0_nx, d0_nx, n1_nx, d1_nx;
	logic                          fail_nx;
	logic signed [V_W-1:0]         n0_s2, d0_s2, n1_s2, d1_s2;
	logic                          fail_s2;
	logic [NUM_EDGES-1:0][V_W-1:0] p_s2, q_s2;

	// a stage loads when empty or when the next one moves
	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	// ratio q/p with a positive denominator; later edges rotate down
	always_comb begin
		p_cur  = $signed(in_p[0]);
		q_cur  = $signed(in_q[0]);
		p_neg  = p_cur[V_W-1];
		p_zero = (p_cur == '0);
		num    = p_neg ? -q_cur : q_cur;
		den    = p_neg ? -p_cur : p_cur;
		p_rot  = {in_p[0], in_p[NUM_EDGES-1:1]};
		q_rot  = {in_q[0], in_q[NUM_EDGES-1:1]};
	end

	// bound compare and interval narrowing
	always_comb begin
		fail_nx = fail_s1;
		n0_nx   = n0_s1;
		d0_nx   = d0_s1;
		n1_nx   = n1_s1;
		d1_nx   = d1_s1;
		if (!fail_s1) begin
			if (zero_s1) begin
				// segment parallel to this edge
				fail_nx = qneg_s1;
			end else if (neg_s1) begin
				// entering edge raises the lower bound
				fail_nx = prod_a_s1 > prod_b_s1;
				if (prod_c_s1 > prod_d_s1) begin
					n0_nx = num_s1;
					d0_nx = den_s1;
				end
			end else begin
				// leaving edge lowers the upper bound
				fail_nx = prod_c_s1 < prod_d_s1;
				if (prod_a_s1 < prod_b_s1) begin
					n1_nx = num_s1;
					d1_nx = den_s1;
				end
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// stage 1 payload: four cross products
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			prod_a_s1 <= P_W'(num) * P_W'(in_d1);
			prod_b_s1 <= P_W'(in_n1) * P_W'(den);
			prod_c_s1 <= P_W'(num) * P_W'(in_d0);
			prod_d_s1 <= P_W'(in_n0) * P_W'(den);
			num_s1    <= num;
			den_s1    <= den;
			neg_s1    <= p_neg;
			zero_s1   <= p_zero;
			qneg_s1   <= q_cur[V_W-1];
			fail_s1   <= in_fail;
			n0_s1     <= in_n0;
			d0_s1     <= in_d0;
			n1_s1     <= in_n1;
			d1_s1     <= in_d1;
			p_s1      <= p_rot;
			q_s1      <= q_rot;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			fail_s2 <= fail_nx;
			n0_s2   <= n0_nx;
			d0_s2   <= d0_nx;
			n1_s2   <= n1_nx;
			d1_s2   <= d1_nx;
			p_s2    <= p_s1;
			q_s2    <= q_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_fail  = fail_s2;
	assign out_n0    = n0_s2;
	assign out_d0    = d0_s2;
	assign out_n1    = n1_s2;
	assign out_d1    = d1_s2;
	assign out_p     = p_s2;
	assign out_q     = q_s2;

endmodule

// ----- rtl/sbct_final.sv -----
// final check that the clipped interval is not empty, output register
`timescale 1ns / 1ps

module sbct_final #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_fail,
	input  logic signed [COORD_WIDTH:0] in_n0,
	input  logic signed [COORD_WIDTH:0] in_d0,
	input  logic signed [COORD_WIDTH:0] in_n1,
	input  logic signed [COORD_WIDTH:0] in_d1,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        touches_box
);

	localparam int P_W = 2 * (COORD_WIDTH + 1);

	logic                  en_s1, en_s2;
	logic                  valid_s1, valid_s2;
	logic signed [P_W-1:0] prod_lo_s1, prod_hi_s1;
	logic                  fail_s1;
	logic                  touches_s2;

	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// t0 <= t1 as n0*d1 <= n1*d0, both denominators positive
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			prod_lo_s1 <= P_W'(in_n0) * P_W'(in_d1);
			prod_hi_s1 <= P_W'(in_n1) * P_W'(in_d0);
			fail_s1    <= in_fail;
		end
		if (en_s2 && valid_s1) begin
			touches_s2 <= !fail_s1 && (prod_lo_s1 <= prod_hi_s1);
		end
	end

	assign out_valid   = valid_s2;
	assign touches_box = touches_s2;

endmodule

// ----- rtl/segment_box_clip_test_top.sv -----
// top level of the segment versus axis-aligned box touch test
`timescale 1ns / 1ps

// Tests whether a 2D segment touches a closed axis-aligned box (edges and corners count),
// using Liang-Barsky clipping with exact rational bounds: ratios are compared by
// cross-multiplication, so there is no rounding. Coordinates are signed fixed point with
// 8 fraction bits. One word enters per cycle while s_tready is high, and one result word
// leaves per input word, in order. From input accept to output valid, one stage forms the
// edge distances, each of the four clip edges takes two stages (a bank of four
// (COORD_WIDTH+1)-bit multipliers, then the bound compare), and the final interval check
// takes two. Stages hold valid bits and fill bubbles, so s_tready stays high while the
// output register is empty or being taken.

module segment_box_clip_test_top import sbct_pkg::*; #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                s_tvalid,
	output logic                                                s_tready,
	// start_x, start_z, end_x, end_z, box_min_x, box_min_z, box_max_x, box_max_z
	input  logic [((NUM_IN_FIELDS*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
	output logic                                                m_tvalid,
	input  logic                                                m_tready,
	// touches_box
	output logic [OUT_DATA_W-1:0]                               m_tdata
);

	localparam int V_W = COORD_WIDTH + 1;

	logic                          prep_valid, prep_ready;
	logic                          st_valid [NUM_EDGES+1];
	logic                          st_ready [NUM_EDGES+1];
	logic                          st_fail  [NUM_EDGES+1];
	logic signed [V_W-1:0]         st_n0    [NUM_EDGES+1];
	logic signed [V_W-1:0]         st_d0    [NUM_EDGES+1];
	logic signed [V_W-1:0]         st_n1    [NUM_EDGES+1];
	logic signed [V_W-1:0]         st_d1    [NUM_EDGES+1];
	logic [NUM_EDGES-1:0][V_W-1:0] st_p     [NUM_EDGES+1];
	logic [NUM_EDGES-1:0][V_W-1:0] st_q     [NUM_EDGES+1];
	logic                          touches_box;

	// edge distances
	sbct_prep #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.start_x   ($signed(s_tdata[0*COORD_WIDTH +: COORD_WIDTH])),
		.start_z   ($signed(s_tdata[1*COORD_WIDTH +: COORD_WIDTH])),
		.end_x     ($signed(s_tdata[2*COORD_WIDTH +: COORD_WIDTH])),
		.end_z     ($signed(s_tdata[3*COORD_WIDTH +: COORD_WIDTH])),
		.box_min_x ($signed(s_tdata[4*COORD_WIDTH +: COORD_WIDTH])),
		.box_min_z ($signed(s_tdata[5*COORD_WIDTH +: COORD_WIDTH])),
		.box_max_x ($signed(s_tdata[6*COORD_WIDTH +: COORD_WIDTH])),
		.box_max_z ($signed(s_tdata[7*COORD_WIDTH +: COORD_WIDTH])),
		.out_valid (prep_valid),
		.out_ready (prep_ready),
		.out_p     (st_p[0]),
		.out_q     (st_q[0])
	);

	// interval starts at [0/1, 1/1] with no edge failed
	assign st_valid[0] = prep_valid;
	assign prep_ready  = st_ready[0];
	assign st_fail[0]  = 1'b0;
	assign st_n0[0]    = V_W'(0);
	assign st_d0[0]    = V_W'(1);
	assign st_n1[0]    = V_W'(1);
	assign st_d1[0]    = V_W'(1);

	// four clip edges in series
	for (genvar g = 0; g < NUM_EDGES; g++) begin : g_edge
		sbct_edge #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_edge (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (st_valid[g]),
			.in_ready  (st_ready[g]),
			.in_fail   (st_fail[g]),
			.in_n0     (st_n0[g]),
			.in_d0     (st_d0[g]),
			.in_n1     (st_n1[g]),
			.in_d1     (st_d1[g]),
			.in_p      (st_p[g]),
			.in_q      (st_q[g]),
			.out_valid (st_valid[g+1]),
			.out_ready (st_ready[g+1]),
			.out_fail  (st_fail[g+1]),
			.out_n0    (st_n0[g+1]),
			.out_d0    (st_d0[g+1]),
			.out_n1    (st_n1[g+1]),
			.out_d1    (st_d1[g+1]),
			.out_p     (st_p[g+1]),
			.out_q     (st_q[g+1])
		);
	end

	// empty-interval check and output register
	sbct_final #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_final (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (st_valid[NUM_EDGES]),
		.in_ready    (st_ready[NUM_EDGES]),
		.in_fail     (st_fail[NUM_EDGES]),
		.in_n0       (st_n0[NUM_EDGES]),
		.in_d0       (st_d0[NUM_EDGES]),
		.in_n1       (st_n1[NUM_EDGES]),
		.in_d1       (st_d1[NUM_EDGES]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.touches_box (touches_box)
	);

	assign m_tdata = {(OUT_DATA_W-1)'(0), touches_box};

	// an empty output register lets the whole pipeline move
	assert property (@(posedge clk) disable iff (!arst_n) !m_tvalid |-> s_tready)
		else $error("input stalled while output register empty");

	// an accepted word lands in the first stage
	assert property (@(posedge clk) disable iff (!arst_n) s_tvalid && s_tready |=> prep_valid)
		else $error("accepted word lost at first stage");

	// the first edge stage drains whenever the output register is empty
	assert property (@(posedge clk) disable iff (!arst_n) !m_tvalid |-> st_ready[0])
		else $error("edge pipeline stalled while output register empty");

endmodule
